### hw/rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// shared widths and the side-band word that travels with the mass divider
// ----------------------------------------------------------------------------
`default_nettype none
package aabb_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned SizeW  = 31;
    localparam int unsigned MassW  = 16;
    // penetration is below 2^31
    localparam int unsigned PenW   = 31;
    // p * m1
    localparam int unsigned NumW   = PenW + MassW;
    // m1 + m2
    localparam int unsigned DenW   = MassW + 1;
    // quotient never exceeds p, one divider stage per quotient bit
    localparam int unsigned QuoW   = PenW;

    typedef struct packed {
        logic            hit;
        logic            vert;
        logic            fix1;
        logic            fix2;
        logic            gt;       // chosen-axis c2 > c1
        logic            lt;       // chosen-axis c2 < c1
        logic            sum_zero; // both masses zero
        logic [PenW-1:0] pen;
    } t_side;

endpackage
`default_nettype wire

### hw/rtl/aabb_div.sv
// ----------------------------------------------------------------------------
// aabb_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [aabb_pkg::NumW-1:0] i_num,
    input  wire logic [aabb_pkg::DenW-1:0] i_den,
    input  wire aabb_pkg::t_side           i_side,
    output logic                           o_valid,
    output logic [aabb_pkg::QuoW-1:0]      o_quo,
    output aabb_pkg::t_side                o_side
);

    localparam int unsigned NS = aabb_pkg::QuoW;
    localparam int unsigned CW = aabb_pkg::NumW + 1;

    logic                      r_v    [NS];
    logic [aabb_pkg::QuoW-1:0] r_q    [NS];
    aabb_pkg::t_side           r_side [NS];
    // remainder and divisor only feed the next stage
    logic [aabb_pkg::NumW-1:0] r_rem  [NS-1];
    logic [aabb_pkg::DenW-1:0] r_den  [NS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_stage
            logic                      v_in;
            logic [aabb_pkg::NumW-1:0] rem_in;
            logic [aabb_pkg::QuoW-1:0] q_in;
            logic [aabb_pkg::DenW-1:0] den_in;
            aabb_pkg::t_side           side_in;
            logic [CW-1:0]             sub_val;
            logic                      take;
            logic [aabb_pkg::QuoW-1:0] n_q;

            // previous stage or the module inputs
            if (gi == 0) begin : g_first
                assign v_in    = i_valid;
                assign rem_in  = i_num;
                assign q_in    = '0;
                assign den_in  = i_den;
                assign side_in = i_side;
            end else begin : g_next
                assign v_in    = r_v[gi-1];
                assign rem_in  = r_rem[gi-1];
                assign q_in    = r_q[gi-1];
                assign den_in  = r_den[gi-1];
                assign side_in = r_side[gi-1];
            end

            // trial subtract of the shifted divisor
            assign sub_val = CW'(den_in) << (NS - 1 - gi);
            assign take    = CW'(rem_in) >= sub_val;

            always_comb begin
                n_q = q_in;
                if (take) begin
                    n_q[NS-1-gi] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[gi] <= 1'b0;
                end else begin
                    r_v[gi] <= v_in;
                end
                r_q[gi]    <= n_q;
                r_side[gi] <= side_in;
            end

            // partial remainder and divisor for the following stage
            if (gi < NS - 1) begin : g_carry
                logic [aabb_pkg::NumW-1:0] n_rem;

                always_comb begin
                    n_rem = rem_in;
                    if (take) begin
                        n_rem = aabb_pkg::NumW'(CW'(rem_in) - sub_val);
                    end
                end

                always_ff @(posedge i_clk) begin
                    r_rem[gi] <= n_rem;
                    r_den[gi] <= den_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NS-1];
    assign o_quo   = r_q[NS-1];
    assign o_side  = r_side[NS-1];

endmodule
`default_nettype wire

### hw/rtl/aabb_pair_collision_resolve.sv
// ----------------------------------------------------------------------------
// aabb_pair_collision_resolve
// overlap test and mass-weighted push-apart for one pair of 2-D boxes
// ----------------------------------------------------------------------------
//  channel   signals                         direction  handshake
//  pair in   start, busy, i_first_*,         in         start & !busy
//            i_second_*
//  result    o_valid, o_hit, o_axis_vertical, out       o_valid, one cycle
//            o_first_shift, o_second_shift
//
//  one pair accepted every cycle, busy is never raised
//  four front stages, 31 divider stages (one quotient
//  bit each), one output stage
//  synchronous active-low reset clears only the valid bits
//  the receiver cannot stall, so nothing in the pipe ever holds
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_pair_collision_resolve (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [aabb_pkg::CoordW-1:0] i_first_x,
    input  wire logic signed [aabb_pkg::CoordW-1:0] i_first_y,
    input  wire logic        [aabb_pkg::SizeW-1:0]  i_first_w,
    input  wire logic        [aabb_pkg::SizeW-1:0]  i_first_h,
    input  wire logic                               i_first_fixed,
    input  wire logic        [aabb_pkg::MassW-1:0]  i_first_mass,
    input  wire logic signed [aabb_pkg::CoordW-1:0] i_second_x,
    input  wire logic signed [aabb_pkg::CoordW-1:0] i_second_y,
    input  wire logic        [aabb_pkg::SizeW-1:0]  i_second_w,
    input  wire logic        [aabb_pkg::SizeW-1:0]  i_second_h,
    input  wire logic                               i_second_fixed,
    input  wire logic        [aabb_pkg::MassW-1:0]  i_second_mass,
    output logic                                    o_valid,
    output logic                                    o_hit,
    output logic                                    o_axis_vertical,
    output logic signed [aabb_pkg::CoordW-1:0]      o_first_shift,
    output logic signed [aabb_pkg::CoordW-1:0]      o_second_shift
);

    localparam int unsigned DiffW = aabb_pkg::CoordW + 1;
    localparam int unsigned SumW  = aabb_pkg::SizeW + 1;
    localparam int unsigned OvW   = aabb_pkg::CoordW + 4;
    localparam int unsigned PenW  = aabb_pkg::PenW;
    localparam int unsigned OutW  = aabb_pkg::CoordW;

    assign busy = 1'b0;

    // stage 1: centre differences and size sums
    logic                         r1_v;
    logic signed [DiffW-1:0]      r1_ddx, r1_ddy;
    logic        [SumW-1:0]       r1_ws, r1_hs;
    logic                         r1_fix1, r1_fix2;
    logic [aabb_pkg::MassW-1:0]   r1_m1, r1_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start;
        end
        r1_ddx  <= DiffW'(i_second_x) - DiffW'(i_first_x);
        r1_ddy  <= DiffW'(i_second_y) - DiffW'(i_first_y);
        r1_ws   <= SumW'(i_first_w) + SumW'(i_second_w);
        r1_hs   <= SumW'(i_first_h) + SumW'(i_second_h);
        r1_fix1 <= i_first_fixed;
        r1_fix2 <= i_second_fixed;
        r1_m1   <= i_first_mass;
        r1_m2   <= i_second_mass;
    end

    // stage 2: doubled overlap per axis
    logic [DiffW-1:0] absx, absy;
    assign absx = r1_ddx[DiffW-1] ? DiffW'(-r1_ddx) : DiffW'(r1_ddx);
    assign absy = r1_ddy[DiffW-1] ? DiffW'(-r1_ddy) : DiffW'(r1_ddy);

    logic                       r2_v;
    logic signed [OvW-1:0]      r2_dx, r2_dy;
    logic                       r2_xgt, r2_xlt, r2_ygt, r2_ylt;
    logic                       r2_fix1, r2_fix2;
    logic [aabb_pkg::MassW-1:0] r2_m1, r2_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_dx   <= signed'(OvW'(r1_ws)) - signed'(OvW'({absx, 1'b0}));
        r2_dy   <= signed'(OvW'(r1_hs)) - signed'(OvW'({absy, 1'b0}));
        r2_xgt  <= !r1_ddx[DiffW-1] && (r1_ddx != '0);
        r2_xlt  <= r1_ddx[DiffW-1];
        r2_ygt  <= !r1_ddy[DiffW-1] && (r1_ddy != '0);
        r2_ylt  <= r1_ddy[DiffW-1];
        r2_fix1 <= r1_fix1;
        r2_fix2 <= r1_fix2;
        r2_m1   <= r1_m1;
        r2_m2   <= r1_m2;
    end

    // stage 3: hit test, axis choice, penetration
    logic                  hit3, vert3;
    logic signed [OvW-1:0] dsel;
    assign hit3  = !(r2_fix1 && r2_fix2) && (r2_dx > 0) && (r2_dy > 0);
    assign vert3 = r2_dx > r2_dy;
    assign dsel  = vert3 ? r2_dy : r2_dx;

    logic                       r3_v;
    aabb_pkg::t_side            r3_side;
    logic [aabb_pkg::MassW-1:0] r3_m1, r3_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_side.hit      <= hit3;
        r3_side.vert     <= vert3;
        r3_side.fix1     <= r2_fix1;
        r3_side.fix2     <= r2_fix2;
        r3_side.gt       <= vert3 ? r2_ygt : r2_xgt;
        r3_side.lt       <= vert3 ? r2_ylt : r2_xlt;
        r3_side.sum_zero <= (r2_m1 == '0) && (r2_m2 == '0);
        r3_side.pen      <= dsel[PenW:1];
        r3_m1            <= r2_m1;
        r3_m2            <= r2_m2;
    end

    // stage 4: numerator p * m1 and mass sum
    logic                           r4_v;
    logic [aabb_pkg::NumW-1:0]      r4_num;
    logic [aabb_pkg::DenW-1:0]      r4_den;
    aabb_pkg::t_side                r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_num  <= aabb_pkg::NumW'(r3_side.pen) * aabb_pkg::NumW'(r3_m1);
        r4_den  <= aabb_pkg::DenW'(r3_m1) + aabb_pkg::DenW'(r3_m2);
        r4_side <= r3_side;
    end

    // mass share divider
    logic                      dv_valid;
    logic [aabb_pkg::QuoW-1:0] dv_quo;
    aabb_pkg::t_side           dv_side;

    aabb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // final: signed shifts
    logic [PenW-1:0]        mv, rest;
    logic signed [OutW-1:0] p_pos, p_neg, mv_pos, mv_neg, rest_pos, rest_neg;
    logic signed [OutW-1:0] n_s1, n_s2;

    assign mv       = dv_side.sum_zero ? '0 : dv_quo;
    assign rest     = dv_side.pen - mv;
    assign p_pos    = signed'(OutW'(dv_side.pen));
    assign p_neg    = -p_pos;
    assign mv_pos   = signed'(OutW'(mv));
    assign mv_neg   = -mv_pos;
    assign rest_pos = signed'(OutW'(rest));
    assign rest_neg = -rest_pos;

    always_comb begin
        n_s1 = '0;
        n_s2 = '0;
        priority if (!dv_side.hit) begin
            n_s1 = '0;
        end else if (!dv_side.fix1 && dv_side.fix2) begin
            n_s1 = dv_side.lt ? p_pos : p_neg;
        end else if (dv_side.fix1) begin
            n_s2 = dv_side.gt ? p_pos : p_neg;
        end else if (dv_side.gt) begin
            n_s2 = mv_pos;
            n_s1 = rest_neg;
        end else begin
            n_s2 = mv_neg;
            n_s1 = rest_pos;
        end
    end

    logic                   r_ov;
    logic                   r_hit, r_vert;
    logic signed [OutW-1:0] r_s1, r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= dv_valid;
        end
        r_hit  <= dv_side.hit;
        r_vert <= dv_side.hit && dv_side.vert;
        r_s1   <= n_s1;
        r_s2   <= n_s2;
    end

    assign o_valid         = r_ov;
    assign o_hit           = r_hit;
    assign o_axis_vertical = r_vert;
    assign o_first_shift   = r_s1;
    assign o_second_shift  = r_s2;

endmodule
`default_nettype wire
